[hdl/svf_pkg.sv]
// ---------------------------------------------------------------------------
// svf_pkg
// types, codes and constants shared by the state variable filter modules
// ---------------------------------------------------------------------------
package svf_pkg;

    localparam int WIDE_W    = 64;
    localparam int MAG_W     = 62;
    localparam int HALF_W    = 31;
    localparam int CFG_W     = 25;
    localparam int CFG_IDX_W = 3;

    localparam logic signed [WIDE_W-1:0] WIDE_LIM = 64'sh2000_0000_0000_0000;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DAMP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FBACK = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL = 3'd5;

    // filter modes
    localparam logic [2:0] MODE_LP   = 3'd0;
    localparam logic [2:0] MODE_HP   = 3'd1;
    localparam logic [2:0] MODE_BP   = 3'd2;
    localparam logic [2:0] MODE_PEAK = 3'd3;
    localparam logic [2:0] MODE_BR   = 3'd4;
    localparam logic [2:0] MODE_BYP  = 3'd5;

    // register reset values
    localparam logic [23:0] RST_GAIN  = 24'd27146;
    localparam logic [23:0] RST_DAMP  = 24'd92682;
    localparam logic [24:0] RST_FBACK = 25'd9546494;
    localparam logic [17:0] RST_DRIVE = 18'd0;
    localparam logic [17:0] RST_LEVEL = 18'd65536;

    // datapath operations
    localparam logic [3:0] OP_NONE  = 4'd0;
    localparam logic [3:0] OP_LOAD  = 4'd1;
    localparam logic [3:0] OP_BYP   = 4'd2;
    localparam logic [3:0] OP_YH    = 4'd3;
    localparam logic [3:0] OP_YHF   = 4'd4;
    localparam logic [3:0] OP_YB    = 4'd5;
    localparam logic [3:0] OP_S1    = 4'd6;
    localparam logic [3:0] OP_YL    = 4'd7;
    localparam logic [3:0] OP_S2    = 4'd8;
    localparam logic [3:0] OP_MIX   = 4'd9;
    localparam logic [3:0] OP_MIXM  = 4'd10;
    localparam logic [3:0] OP_CLAMP = 4'd11;
    localparam logic [3:0] OP_XX    = 4'd12;
    localparam logic [3:0] OP_NUM   = 4'd13;
    localparam logic [3:0] OP_DIV   = 4'd14;
    localparam logic [3:0] OP_SHP   = 4'd15;

    // multiplier operand selects
    localparam logic [2:0] A_S1  = 3'd0;
    localparam logic [2:0] A_YH  = 3'd1;
    localparam logic [2:0] A_YB  = 3'd2;
    localparam logic [2:0] A_MIX = 3'd3;
    localparam logic [2:0] A_AX  = 3'd4;
    localparam logic [2:0] A_T   = 3'd5;

    localparam logic [2:0] B_RG  = 3'd0;
    localparam logic [2:0] B_H   = 3'd1;
    localparam logic [2:0] B_G   = 3'd2;
    localparam logic [2:0] B_R2  = 3'd3;
    localparam logic [2:0] B_DRV = 3'd4;
    localparam logic [2:0] B_AX  = 3'd5;
    localparam logic [2:0] B_LVL = 3'd6;

    localparam logic [1:0] SH_16   = 2'd0;
    localparam logic [1:0] SH_24   = 2'd1;
    localparam logic [1:0] SH_FRAC = 2'd2;

    typedef struct packed {
        logic       mul_en;
        logic [1:0] mphase;
        logic [2:0] a_sel;
        logic [2:0] b_sel;
        logic [1:0] sh_sel;
        logic [3:0] op;
        logic       div_first;
        logic       out_write;
    } cmd_t;

    typedef struct packed {
        logic bypass;
        logic peak;
        logic out_busy;
    } status_t;

    function automatic logic signed [WIDE_W-1:0] sat_wide(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] r;
        r = v;
        if (v > WIDE_LIM)
            r = WIDE_LIM;
        else if (v < -WIDE_LIM)
            r = -WIDE_LIM;
        return r;
    endfunction

endpackage

[hdl/state_variable_filter_unit.sv]
// ---------------------------------------------------------------------------
// state_variable_filter_unit
// trapezoidal state variable filter with drive, tanh shaping and output level
// ---------------------------------------------------------------------------
//  channel  handshake              payload
//  input    in_valid / in_ready    sample_in
//  output   out_valid / out_ready  sample_out
//  config   cfg_write              cfg_index, cfg_data
//
// a filtered word takes one more multiply in peak bandpass mode before it
// reaches the output register, and bypass copies the input word straight there
// a word holds the sequencer until it is written to a free output register
// the work is done by one shared multiplier and the bit-serial divider of the
// tanh approximation (one quotient bit a cycle)
// in_ready is high only while the sequencer is idle; a finished word waits in
// the output register and the next word is taken meanwhile
// reset clears both integrators and loads the default coefficients
module state_variable_filter_unit #(
    parameter int SAMPLE_BITS = 24,
    parameter int STATE_BITS  = 40
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [svf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [svf_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] sample_out
);
    import svf_pkg::*;

    cmd_t    cmd;
    status_t status;

    svf_ctrl #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    svf_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .STATE_BITS  (STATE_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sample_in  (sample_in),
        .sample_out (sample_out),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .cmd        (cmd),
        .status     (status)
    );

endmodule

[hdl/svf_ctrl.sv]
// ---------------------------------------------------------------------------
// svf_ctrl
// sequencer: steps the shared multiplier, the adders and the divider
// ---------------------------------------------------------------------------
module svf_ctrl #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  svf_pkg::status_t status,
    output svf_pkg::cmd_t    cmd
);
    import svf_pkg::*;

    localparam int FRAC = SAMPLE_BITS - 2;
    localparam int CW   = $clog2(FRAC + 1);
    localparam logic [CW-1:0] DIV_LAST = CW'(FRAC);
    localparam logic [CW-1:0] MUL_LAST = CW'(3);

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_BYP   = 5'd1;
    localparam logic [4:0] ST_M1    = 5'd2;
    localparam logic [4:0] ST_YH    = 5'd3;
    localparam logic [4:0] ST_M2    = 5'd4;
    localparam logic [4:0] ST_YHF   = 5'd5;
    localparam logic [4:0] ST_M3    = 5'd6;
    localparam logic [4:0] ST_YB    = 5'd7;
    localparam logic [4:0] ST_S1    = 5'd8;
    localparam logic [4:0] ST_M4    = 5'd9;
    localparam logic [4:0] ST_YL    = 5'd10;
    localparam logic [4:0] ST_S2    = 5'd11;
    localparam logic [4:0] ST_MIX   = 5'd12;
    localparam logic [4:0] ST_M5    = 5'd13;
    localparam logic [4:0] ST_MIXM  = 5'd14;
    localparam logic [4:0] ST_M6    = 5'd15;
    localparam logic [4:0] ST_CLAMP = 5'd16;
    localparam logic [4:0] ST_M7    = 5'd17;
    localparam logic [4:0] ST_XX    = 5'd18;
    localparam logic [4:0] ST_M8    = 5'd19;
    localparam logic [4:0] ST_NUM   = 5'd20;
    localparam logic [4:0] ST_DIV   = 5'd21;
    localparam logic [4:0] ST_SHP   = 5'd22;
    localparam logic [4:0] ST_M9    = 5'd23;
    localparam logic [4:0] ST_OUT   = 5'd24;

    logic [4:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [4:0]    mul_dest;

    always_comb
    begin
        cmd        = '0;
        cmd.mphase = cnt_reg[1:0];
        state_next = state_reg;
        cnt_next   = cnt_reg;
        mul_dest   = ST_IDLE;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = status.bypass ? ST_BYP : ST_M1;
                end
            end
            ST_BYP:
            begin
                if (!status.out_busy)
                begin
                    cmd.op        = OP_BYP;
                    cmd.out_write = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_M1:
            begin
                cmd.mul_en = 1'b1; cmd.a_sel = A_S1; cmd.b_sel = B_RG;
                cmd.sh_sel = SH_16; mul_dest = ST_YH;
            end
            ST_YH:    begin cmd.op = OP_YH; state_next = ST_M2; end
            ST_M2:
            begin
                cmd.mul_en = 1'b1; cmd.a_sel = A_YH; cmd.b_sel = B_H;
                cmd.sh_sel = SH_24; mul_dest = ST_YHF;
            end
            ST_YHF:   begin cmd.op = OP_YHF; state_next = ST_M3; end
            ST_M3:
            begin
                cmd.mul_en = 1'b1; cmd.a_sel = A_YH; cmd.b_sel = B_G;
                cmd.sh_sel = SH_16; mul_dest = ST_YB;
            end
            ST_YB:    begin cmd.op = OP_YB; state_next = ST_S1; end
            ST_S1:    begin cmd.op = OP_S1; state_next = ST_M4; end
            ST_M4:
            begin
                cmd.mul_en = 1'b1; cmd.a_sel = A_YB; cmd.b_sel = B_G;
                cmd.sh_sel = SH_16; mul_dest = ST_YL;
            end
            ST_YL:    begin cmd.op = OP_YL; state_next = ST_S2; end
            ST_S2:    begin cmd.op = OP_S2; state_next = ST_MIX; end
            ST_MIX:
            begin
                cmd.op     = OP_MIX;
                state_next = status.peak ? ST_M5 : ST_M6;
            end
            ST_M5:
            begin
                cmd.mul_en = 1'b1; cmd.a_sel = A_YB; cmd.b_sel = B_R2;
                cmd.sh_sel = SH_16; mul_dest = ST_MIXM;
            end
            ST_MIXM:  begin cmd.op = OP_MIXM; state_next = ST_M6; end
            ST_M6:
            begin
                cmd.mul_en = 1'b1; cmd.a_sel = A_MIX; cmd.b_sel = B_DRV;
                cmd.sh_sel = SH_16; mul_dest = ST_CLAMP;
            end
            ST_CLAMP: begin cmd.op = OP_CLAMP; state_next = ST_M7; end
            ST_M7:
            begin
                cmd.mul_en = 1'b1; cmd.a_sel = A_AX; cmd.b_sel = B_AX;
                cmd.sh_sel = SH_FRAC; mul_dest = ST_XX;
            end
            ST_XX:    begin cmd.op = OP_XX; state_next = ST_M8; end
            ST_M8:
            begin
                cmd.mul_en = 1'b1; cmd.a_sel = A_T; cmd.b_sel = B_AX;
                cmd.sh_sel = SH_FRAC; mul_dest = ST_NUM;
            end
            ST_NUM:   begin cmd.op = OP_NUM; state_next = ST_DIV; cnt_next = '0; end
            ST_DIV:
            begin
                // integer bit first, then one fraction bit a cycle
                cmd.op        = OP_DIV;
                cmd.div_first = (cnt_reg == '0);
                if (cnt_reg == DIV_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_SHP;
                end
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_SHP:   begin cmd.op = OP_SHP; state_next = ST_M9; end
            ST_M9:
            begin
                cmd.mul_en = 1'b1; cmd.a_sel = A_MIX; cmd.b_sel = B_LVL;
                cmd.sh_sel = SH_16; mul_dest = ST_OUT;
            end
            ST_OUT:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_write = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase

        // a multiply steps through operands, low half, high half and round, then moves on
        if (cmd.mul_en)
        begin
            if (cnt_reg == MUL_LAST)
            begin
                cnt_next   = '0;
                state_next = mul_dest;
            end
            else
                cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

[hdl/svf_datapath.sv]
// ---------------------------------------------------------------------------
// svf_datapath
// registers, shared multiplier, adders, divider and output word register
// ---------------------------------------------------------------------------
module svf_datapath #(
    parameter int SAMPLE_BITS = 24,
    parameter int STATE_BITS  = 40
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [svf_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [svf_pkg::CFG_W-1:0]             cfg_data,
    input  logic signed [SAMPLE_BITS-1:0]         sample_in,
    output logic signed [SAMPLE_BITS-1:0]         sample_out,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    input  svf_pkg::cmd_t                         cmd,
    output svf_pkg::status_t                      status
);
    import svf_pkg::*;

    localparam int FRAC  = SAMPLE_BITS - 2;
    localparam int BW    = (SAMPLE_BITS > 25) ? SAMPLE_BITS : 25;
    localparam int ACC_W = MAG_W + BW;
    localparam int PP_W  = HALF_W + BW;
    localparam int DW    = FRAC + 8;
    localparam int QW    = FRAC + 2;
    localparam int TW    = FRAC + 7;

    localparam logic signed [WIDE_W-1:0] LIM3   = WIDE_W'(3) << FRAC;
    localparam logic [TW-1:0]            K27    = TW'(27) << FRAC;
    localparam logic signed [WIDE_W-1:0] ST_MAX = (WIDE_W'(1) << (STATE_BITS - 1)) - 1;
    localparam logic signed [WIDE_W-1:0] ST_MIN = -(WIDE_W'(1) << (STATE_BITS - 1));
    localparam logic signed [WIDE_W-1:0] SM_MAX = (WIDE_W'(1) << (SAMPLE_BITS - 1)) - 1;
    localparam logic signed [WIDE_W-1:0] SM_MIN = -(WIDE_W'(1) << (SAMPLE_BITS - 1));

    // configuration
    logic [2:0]  mode_reg;
    logic [23:0] gain_reg, damp_reg;
    logic [24:0] fback_reg;
    logic [17:0] drive_reg, level_reg;

    // filter state and working registers
    logic signed [STATE_BITS-1:0]  s1_reg, s2_reg;
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic signed [WIDE_W-1:0]      yh_reg, yb_reg, yl_reg, mix_reg, m_reg;
    logic [SAMPLE_BITS-1:0]        ax_reg;
    logic                          neg_reg;
    logic [TW-1:0]                 t_reg, den_reg;
    logic [DW-1:0]                 rem_reg;
    logic [QW-1:0]                 q_reg;
    logic signed [SAMPLE_BITS-1:0] out_reg;
    logic                          out_valid_reg;

    // multiplier
    logic [MAG_W-1:0]  mag_reg;
    logic              sgn_reg;
    logic [BW-1:0]     b_reg;
    logic [ACC_W-1:0]  acc_reg;

    logic signed [WIDE_W-1:0] s1_w, s2_w, x_w, a_w, a_abs;
    logic [BW-1:0]            b_w;
    logic [PP_W-1:0]          pp_lo, pp_hi;
    logic [ACC_W:0]           rnd_sum, rnd_shift, rnd_half;
    logic [WIDE_W-1:0]        rnd_mag;
    logic signed [WIDE_W-1:0] m_next;
    logic signed [WIDE_W-1:0] yh_sum, yb_sum, yl_sum, s_sum, s_sat, mix_sel, clamp_v;
    logic [DW-1:0]            div_r, div_d;
    logic                     div_ge;
    logic signed [WIDE_W-1:0] out_wide;

    assign s1_w = WIDE_W'(s1_reg);
    assign s2_w = WIDE_W'(s2_reg);
    assign x_w  = WIDE_W'(x_reg);

    // partial products of the two magnitude halves
    assign pp_lo = PP_W'(mag_reg[HALF_W-1:0]) * PP_W'(b_reg);
    assign pp_hi = PP_W'(mag_reg[MAG_W-1:HALF_W]) * PP_W'(b_reg);

    always_comb
    begin
        case (cmd.a_sel)
            A_S1:    a_w = s1_w;
            A_YH:    a_w = yh_reg;
            A_YB:    a_w = yb_reg;
            A_MIX:   a_w = mix_reg;
            A_AX:    a_w = WIDE_W'({1'b0, ax_reg});
            A_T:     a_w = WIDE_W'({1'b0, t_reg});
            default: a_w = '0;
        endcase
        a_abs = (a_w < 0) ? -a_w : a_w;
        case (cmd.b_sel)
            B_RG:    b_w = BW'({1'b0, damp_reg} + {1'b0, gain_reg});
            B_H:     b_w = BW'(fback_reg);
            B_G:     b_w = BW'(gain_reg);
            B_R2:    b_w = BW'(damp_reg);
            B_DRV:   b_w = BW'(20'd65536 + 20'd3 * {2'b00, drive_reg});
            B_AX:    b_w = BW'(ax_reg);
            B_LVL:   b_w = BW'(level_reg);
            default: b_w = '0;
        endcase
    end

    // round to nearest, ties away from zero, then clamp the magnitude
    always_comb
    begin
        case (cmd.sh_sel)
            SH_16:   rnd_half = (ACC_W+1)'(1) << 15;
            SH_24:   rnd_half = (ACC_W+1)'(1) << 23;
            default: rnd_half = (ACC_W+1)'(1) << (FRAC - 1);
        endcase
        rnd_sum = {1'b0, acc_reg} + rnd_half;
        case (cmd.sh_sel)
            SH_16:   rnd_shift = rnd_sum >> 16;
            SH_24:   rnd_shift = rnd_sum >> 24;
            default: rnd_shift = rnd_sum >> FRAC;
        endcase
        if (rnd_shift > (ACC_W+1)'(WIDE_LIM))
            rnd_mag = WIDE_LIM;
        else
            rnd_mag = rnd_shift[WIDE_W-1:0];
        m_next = sgn_reg ? -$signed(rnd_mag) : $signed(rnd_mag);
    end

    // adders for the filter step, mode mix select, clamps and divider compare
    always_comb
    begin
        yh_sum = sat_wide(x_w - m_reg - s2_w);
        yb_sum = sat_wide(m_reg + s1_w);
        yl_sum = sat_wide(m_reg + s2_w);
        s_sum  = (cmd.op == OP_S1) ? (m_reg + yb_reg) : (m_reg + yl_reg);
        if (s_sum > ST_MAX)
            s_sat = ST_MAX;
        else if (s_sum < ST_MIN)
            s_sat = ST_MIN;
        else
            s_sat = s_sum;
        case (mode_reg)
            MODE_LP: mix_sel = yl_reg;
            MODE_HP: mix_sel = yh_reg;
            MODE_BR: mix_sel = sat_wide(yl_reg + yh_reg);
            default: mix_sel = yb_reg;
        endcase
        if (m_reg > LIM3)
            clamp_v = LIM3;
        else if (m_reg < -LIM3)
            clamp_v = -LIM3;
        else
            clamp_v = m_reg;
        div_r  = cmd.div_first ? rem_reg : {rem_reg[DW-2:0], 1'b0};
        div_d  = DW'(den_reg);
        div_ge = (div_r >= div_d);
        if (m_reg > SM_MAX)
            out_wide = SM_MAX;
        else if (m_reg < SM_MIN)
            out_wide = SM_MIN;
        else
            out_wide = m_reg;
    end

    // output valid flag, configuration and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_LP;
            gain_reg      <= RST_GAIN;
            damp_reg      <= RST_DAMP;
            fback_reg     <= RST_FBACK;
            drive_reg     <= RST_DRIVE;
            level_reg     <= RST_LEVEL;
            s1_reg        <= '0;
            s2_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_MODE:  mode_reg  <= cfg_data[2:0];
                    CFG_GAIN:  gain_reg  <= cfg_data[23:0];
                    CFG_DAMP:  damp_reg  <= cfg_data[23:0];
                    CFG_FBACK: fback_reg <= cfg_data[24:0];
                    CFG_DRIVE: drive_reg <= cfg_data[17:0];
                    CFG_LEVEL: level_reg <= cfg_data[17:0];
                    default:   ;
                endcase
            end
            if (cmd.op == OP_S1)
                s1_reg <= s_sat[STATE_BITS-1:0];
            if (cmd.op == OP_S2)
                s2_reg <= s_sat[STATE_BITS-1:0];
            if (cmd.out_write)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            case (cmd.mphase)
                2'd0:
                begin
                    mag_reg <= a_abs[MAG_W-1:0];
                    sgn_reg <= (a_w < 0);
                    b_reg   <= b_w;
                end
                2'd1: acc_reg <= ACC_W'(pp_lo);
                2'd2: acc_reg <= acc_reg + (ACC_W'(pp_hi) << HALF_W);
                default: m_reg <= m_next;
            endcase
        end
        case (cmd.op)
            OP_LOAD:  x_reg   <= sample_in;
            OP_YH:    yh_reg  <= yh_sum;
            OP_YHF:   yh_reg  <= m_reg;
            OP_YB:    yb_reg  <= yb_sum;
            OP_YL:    yl_reg  <= yl_sum;
            OP_MIX:   mix_reg <= mix_sel;
            OP_MIXM:  mix_reg <= m_reg;
            OP_CLAMP:
            begin
                neg_reg <= (clamp_v < 0);
                ax_reg  <= (clamp_v < 0) ? SAMPLE_BITS'(-clamp_v) : SAMPLE_BITS'(clamp_v);
            end
            OP_XX:
            begin
                t_reg   <= K27 + TW'(m_reg);
                den_reg <= K27 + TW'(9) * TW'(m_reg);
            end
            OP_NUM:
            begin
                rem_reg <= DW'(m_reg);
                q_reg   <= '0;
            end
            OP_DIV:
            begin
                rem_reg <= div_ge ? (div_r - div_d) : div_r;
                q_reg   <= {q_reg[QW-2:0], div_ge};
            end
            OP_SHP:   mix_reg <= neg_reg ? -WIDE_W'(q_reg) : WIDE_W'(q_reg);
            default:  ;
        endcase
        if (cmd.out_write)
            out_reg <= (cmd.op == OP_BYP) ? x_reg : out_wide[SAMPLE_BITS-1:0];
    end

    assign sample_out      = out_reg;
    assign out_valid       = out_valid_reg;
    assign status.bypass   = (mode_reg >= MODE_BYP);
    assign status.peak     = (mode_reg == MODE_PEAK);
    assign status.out_busy = out_valid_reg && !out_ready;

endmodule

[hdl/svf_checker.sv]
// ---------------------------------------------------------------------------
// svf_checker
// port-level checks on the filter's handshakes
// ---------------------------------------------------------------------------
module svf_checker #(
    parameter int SAMPLE_BITS = 24
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic signed [SAMPLE_BITS-1:0] sample_out
);

    // one word at a time: busy right after taking a word
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a word is in progress");

    // idle with nothing offered stays idle
    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready && !in_valid |=> in_ready)
        else $error("sequencer left idle without a word");

    // a result never appears in the cycle straight after acceptance
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> !out_valid)
        else $error("result appeared too early");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sample_out))
        else $error("stalled output word changed");

endmodule

bind state_variable_filter_unit svf_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_svf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out)
);

[dv/tb_state_variable_filter_unit.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_state_variable_filter_unit
// self-checking bench for the state variable filter: a queue-fed driver and
// a monitor compare every output word against an in-bench fixed-point model
// run across many coefficient and mode settings with random handshake gaps
// ---------------------------------------------------------------------------
module tb_state_variable_filter_unit;

    import svf_pkg::*;

    localparam int SB        = 24;
    localparam int FRB       = SB - 2;
    localparam int NSTATE    = 40;
    localparam int TIMEOUT   = 4000;
    localparam int N_PHASES  = 32;
    localparam int PHASE_LEN = 50;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic signed [SB-1:0] sample_in = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic signed [SB-1:0] sample_out;

    state_variable_filter_unit #(
        .SAMPLE_BITS(SB),
        .STATE_BITS (NSTATE)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .sample_in (sample_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sample_out(sample_out)
    );

    // model copy of the registers and integrators
    logic [2:0]  m_mode  = MODE_LP;
    logic [23:0] m_gain  = RST_GAIN;
    logic [23:0] m_damp  = RST_DAMP;
    logic [24:0] m_fback = RST_FBACK;
    logic [17:0] m_drive = RST_DRIVE;
    logic [17:0] m_level = RST_LEVEL;
    longint      band_acc = 0;
    longint      low_acc = 0;

    logic signed [SB-1:0] pending_samples[$];
    logic signed [SB-1:0] expected_samples[$];

    int  in_gap = 0;
    int  out_gap = 0;
    bit  no_idle = 1'b0;
    int  mismatches = 0;
    int  stall_cycles = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(5, 40);
    endfunction

    // (a*b) >> sh rounded half away from zero, saturated at +-2^61
    function automatic longint mul_round(longint a, longint unsigned b, int sh);
        bit neg;
        longint unsigned mag, lo, hi, plo, phi, res, lim;
        lim = 64'h2000_0000_0000_0000;
        neg = a < 0;
        mag = neg ? 64'd0 - longint'(unsigned'(a)) : longint'(unsigned'(a));
        b   = b & 64'hFFFF_FFFF;
        lo  = mag & 64'hFFFF_FFFF;
        hi  = mag >> 32;
        plo = lo * b;
        phi = hi * b;
        if (phi > (lim >> (32 - sh)))
            res = lim;
        else
        begin
            res = (phi << (32 - sh)) + (plo >> sh);
            if ((plo & ((64'd1 << sh) - 1)) >= (64'd1 << (sh - 1)))
                res = res + 1;
            if (res > lim)
                res = lim;
        end
        return neg ? -longint'(res) : longint'(res);
    endfunction

    function automatic longint clip_wide(longint v);
        longint lim;
        lim = 64'sh2000_0000_0000_0000;
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    function automatic longint clip_bits(longint v, int bits);
        longint hi;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        if (v > hi)
            return hi;
        if (v < -hi - 1)
            return -hi - 1;
        return v;
    endfunction

    function automatic longint tanh_approx(longint x);
        longint one, lim;
        bit neg;
        longint unsigned ax, xx, num, den, q, r;
        one = longint'(1) <<< FRB;
        lim = 3 * one;
        if (x > lim)
            x = lim;
        if (x < -lim)
            x = -lim;
        neg = x < 0;
        ax  = neg ? -x : x;
        xx  = mul_round(ax, ax, FRB);
        num = mul_round(27 * one + xx, ax, FRB);
        den = 27 * one + 9 * xx;
        q   = num / den;
        r   = num % den;
        for (int i = 0; i < FRB; i++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= den)
            begin
                r = r - den;
                q = q | 1;
            end
        end
        return neg ? -longint'(q) : longint'(q);
    endfunction

    // one filter step: outside bypass updates the integrators; returns the output word
    function automatic logic signed [SB-1:0] filter_sample(logic signed [SB-1:0] s);
        longint x, yh, yb, yl, gy, mix, res;
        longint unsigned g;
        x = longint'(s);
        g = longint'(m_gain);
        if (m_mode >= MODE_BYP)
            return s;
        yh = clip_wide(x - mul_round(band_acc, m_damp + g, 16) - low_acc);
        yh = mul_round(yh, m_fback, 24);
        gy = mul_round(yh, g, 16);
        yb = clip_wide(gy + band_acc);
        band_acc = clip_bits(gy + yb, NSTATE);
        gy = mul_round(yb, g, 16);
        yl = clip_wide(gy + low_acc);
        low_acc = clip_bits(gy + yl, NSTATE);
        case (m_mode)
            MODE_LP:   mix = yl;
            MODE_HP:   mix = yh;
            MODE_BP:   mix = yb;
            MODE_PEAK: mix = mul_round(yb, m_damp, 16);
            default:   mix = clip_wide(yl + yh);
        endcase
        mix = mul_round(mix, 65536 + 3 * longint'(m_drive), 16);
        res = clip_bits(mul_round(tanh_approx(mix), m_level, 16), SB);
        return res[SB-1:0];
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            sample_in <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_samples.push_back(filter_sample(pending_samples.pop_front()));
                in_gap = pick_gap();
            end
            if (!in_valid || in_ready)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_samples.size() > 0)
                begin
                    in_valid  <= 1'b1;
                    sample_in <= pending_samples[0];
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_samples.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected output word %0d", sample_out);
                end
                else
                begin
                    logic signed [SB-1:0] want;
                    want = expected_samples.pop_front();
                    if (sample_out !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("sample_out mismatch: expected %0d, got %0d",
                                     want, sample_out);
                    end
                end
                out_gap = pick_gap();
            end
            if (out_gap > 0)
            begin
                out_gap--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // watchdog on handshake activity
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= TIMEOUT)
        begin
            $display("** state_variable_filter_unit: FAILED **");
            $finish;
        end
    end

    task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_MODE:  m_mode  = val[2:0];
            CFG_GAIN:  m_gain  = val[23:0];
            CFG_DAMP:  m_damp  = val[23:0];
            CFG_FBACK: m_fback = val[24:0];
            CFG_DRIVE: m_drive = val[17:0];
            CFG_LEVEL: m_level = val[17:0];
            default: ;
        endcase
    endtask

    task automatic reg_done();
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic drain();
        wait (pending_samples.size() == 0 && expected_samples.size() == 0 && !in_valid);
        repeat (20) @(posedge clk);
    endtask

    // register value, sometimes with random junk above the register width
    function automatic logic [CFG_W-1:0] with_junk(logic [CFG_W-1:0] v, int w);
        logic [CFG_W-1:0] junk;
        junk = CFG_W'($urandom);
        if (w < CFG_W && $urandom_range(0, 9) == 0)
            v = v | (junk & ~((25'd1 << w) - 1));
        return v;
    endfunction

    function automatic logic signed [SB-1:0] pick_sample(int amp_log);
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $signed(SB'($urandom)) >>> (SB - 1 - amp_log);
        else if (r < 85)
            return SB'($urandom);
        else if (r < 92)
            return (r & 1) ? 24'sh7FFFFF : 24'sh800000;
        else
            return '0;
    endfunction

    initial
    begin
        int           amp_log;
        int           x;
        real          gr, rr;
        logic [23:0]  g, r2;
        logic [24:0]  h;
        logic [17:0]  drv, lvl;
        logic [2:0]   md;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: extremes at reset coefficients, then each mode code
        pending_samples = '{24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF,
                            24'sh800000, 24'sh800000, 24'sh800000,
                            24'sh000000, 24'sh000001, -24'sh000001};
        drain();
        for (int m = 1; m < 8; m++)
        begin
            reg_write(CFG_MODE, 25'(m));
            reg_done();
            pending_samples.push_back(24'sh7FFFFF);
            pending_samples.push_back(24'sh800000);
            drain();
        end

        for (int p = 0; p < N_PHASES; p++)
        begin
            // coefficients of a stable filter most of the time
            g   = 24'($urandom_range(500, 60000));
            r2  = 24'($urandom_range(0, 140000));
            gr  = real'(g) / 65536.0;
            rr  = real'(r2) / 65536.0;
            x   = int'(16777216.0 / (1.0 + rr * gr + gr * gr));
            h   = 25'(x);
            drv = ($urandom_range(0, 2) == 0) ? 18'($urandom_range(0, 40000)) : 18'd0;
            lvl = 18'($urandom_range(20000, 131072));
            md  = (p < 8) ? 3'(p) : 3'($urandom_range(0, 7));
            if ($urandom_range(0, 99) < 20 || p == 8)
            begin
                // an extreme setting
                g   = (p & 1) ? 24'hFFFFFF : 24'd0;
                r2  = (p & 2) ? 24'hFFFFFF : 24'd0;
                h   = (p & 4) ? 25'h1000000 : 25'd0;
                drv = (p & 8) ? 18'h3FFFF : 18'd0;
                lvl = (p & 16) ? 18'h3FFFF : 18'd0;
            end
            if (p == N_PHASES - 1)
            begin
                drv = 18'h3FFFF;
                lvl = 18'h3FFFF;
            end
            reg_write(CFG_MODE,  with_junk(25'(md), 3));
            reg_write(CFG_GAIN,  with_junk(25'(g), 24));
            reg_write(CFG_DAMP,  with_junk(25'(r2), 24));
            reg_write(CFG_FBACK, 25'(h));
            reg_write(CFG_DRIVE, with_junk(25'(drv), 18));
            reg_write(CFG_LEVEL, with_junk(25'(lvl), 18));
            if ($urandom_range(0, 3) == 0)
                reg_write(3'($urandom_range(6, 7)), 25'($urandom));
            reg_done();

            no_idle = ($urandom_range(0, 3) == 0);
            amp_log = $urandom_range(4, 22);
            for (int i = 0; i < PHASE_LEN; i++)
                pending_samples.push_back(pick_sample(amp_log));
            drain();
        end

        repeat (100) @(posedge clk);
        if (mismatches == 0 && expected_samples.size() == 0)
            $display("** state_variable_filter_unit: PASSED **");
        else
            $display("** state_variable_filter_unit: FAILED **");
        $finish;
    end

endmodule

[filelist.f]
hdl/svf_pkg.sv
hdl/svf_ctrl.sv
hdl/svf_datapath.sv
hdl/state_variable_filter_unit.sv
hdl/svf_checker.sv
dv/tb_state_variable_filter_unit.sv
